// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: property failed");
// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- rtl/core/tft_pkg.sv -----
// ----------------------------------------------------------------------------
// Text format tokenizer package
// Types, character codes and helper functions for the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tft_pkg;

	localparam logic [15:0] SAT_MAX = 16'hFFFF;
	localparam int unsigned RES_DEPTH = 4;

	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	typedef enum logic [3:0] {
		M_IDLE    = 4'd0,
		M_COMMENT = 4'd1,
		M_IDENT   = 4'd2,
		M_SIGN    = 4'd3,
		M_NUM     = 4'd4,
		M_STR     = 4'd5,
		M_ESC     = 4'd6,
		M_AT      = 4'd7,
		M_DIR     = 4'd8
	} mode_t;

	typedef enum logic [2:0] {
		K_IDENT     = 3'd0,
		K_NUMBER    = 3'd1,
		K_KEYWORD   = 3'd2,
		K_STRING    = 3'd3,
		K_DIRECTIVE = 3'd4,
		K_PUNCT     = 3'd5,
		K_ERROR     = 3'd6,
		K_END       = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE       = 3'd0,
		E_BAD_CHAR   = 3'd1,
		E_BAD_ESCAPE = 3'd2,
		E_EOF_STR    = 3'd3,
		E_NL_STR     = 3'd4
	} err_t;

	// Special word codes: 0 none, 1 inf, 2 nan, 3 true, 4 false
	typedef enum logic [2:0] {
		W_NONE  = 3'd0,
		W_INF   = 3'd1,
		W_NAN   = 3'd2,
		W_TRUE  = 3'd3,
		W_FALSE = 3'd4
	} word_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] row;
		logic [15:0] col;
		logic [15:0] len;
		logic        first;
		err_t        err;
		logic        last;
	} res_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v != SAT_MAX) ? v + 16'd1 : v;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic ident_start(input logic [7:0] c);
		return is_alpha(c) || c == CH_UNDER;
	endfunction

	function automatic logic ident_part(input logic [7:0] c);
		return ident_start(c) || is_digit(c);
	endfunction

	function automatic logic num_part(input logic [7:0] c);
		return ident_part(c) || c == CH_DOT;
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return c >= 8'd33 && c <= 8'd126 && !is_alpha(c) && !is_digit(c);
	endfunction

	function automatic word_t word_first(input logic [7:0] c);
		word_t w;
		unique case (c)
			8'h69:   w = W_INF;
			8'h6E:   w = W_NAN;
			8'h74:   w = W_TRUE;
			8'h66:   w = W_FALSE;
			default: w = W_NONE;
		endcase
		return w;
	endfunction

	function automatic logic [2:0] word_len(input word_t w);
		logic [2:0] n;
		unique case (w)
			W_INF, W_NAN: n = 3'd3;
			W_TRUE:       n = 3'd4;
			W_FALSE:      n = 3'd5;
			default:      n = 3'd0;
		endcase
		return n;
	endfunction

	// Expected byte of a special word at a position below five
	function automatic logic [7:0] word_char(input word_t w, input logic [2:0] p);
		logic [7:0] c;
		c = 8'h00;
		unique case (w)
			W_INF: begin
				unique case (p)
					3'd0:    c = 8'h69;
					3'd1:    c = 8'h6E;
					3'd2:    c = 8'h66;
					default: c = 8'h00;
				endcase
			end
			W_NAN: begin
				unique case (p)
					3'd0:    c = 8'h6E;
					3'd1:    c = 8'h61;
					3'd2:    c = 8'h6E;
					default: c = 8'h00;
				endcase
			end
			W_TRUE: begin
				unique case (p)
					3'd0:    c = 8'h74;
					3'd1:    c = 8'h72;
					3'd2:    c = 8'h75;
					3'd3:    c = 8'h65;
					default: c = 8'h00;
				endcase
			end
			W_FALSE: begin
				unique case (p)
					3'd0:    c = 8'h66;
					3'd1:    c = 8'h61;
					3'd2:    c = 8'h6C;
					3'd3:    c = 8'h73;
					3'd4:    c = 8'h65;
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Keep the word match only if the byte continues the word at tlen - off
	function automatic word_t word_step(input word_t w, input logic [15:0] tlen,
			input logic off, input logic [7:0] c);
		logic [15:0] p;
		word_t       r;
		p = tlen - {15'd0, off};
		r = W_NONE;
		if (w != W_NONE && tlen >= {15'd0, off} && p < {13'd0, word_len(w)} &&
				word_char(w, p[2:0]) == c) begin
			r = w;
		end
		return r;
	endfunction

	function automatic logic word_done(input word_t w, input logic [15:0] tlen,
			input logic off);
		return w != W_NONE && tlen >= {15'd0, off} &&
			(tlen - {15'd0, off}) == {13'd0, word_len(w)};
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/text_format_tokenizer.sv -----
// Path: a transferred byte is registered in the input stage, scanned there, and
// its results are pushed into the result queue, whose head drives the outputs.
// Throughput: one byte per cycle while the result queue holds at most two
// entries; a byte may yield two results, which the four-entry queue absorbs.
// Reset (arst_n low): scanner back between tokens at row 1, column 1,
// input stage and result queue emptied.
// ----------------------------------------------------------------------------
// Text format tokenizer
// Scans one source byte per cycle unless stalled, tracks row and column, and
// emits tokens: kind, start position, length, first-on-line flag, error kind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module text_format_tokenizer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [7:0]          char_byte,
	input  wire logic                end_marker,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [2:0]               token_kind,
	output logic [15:0]              token_row,
	output logic [15:0]              token_col,
	output logic [15:0]              token_length,
	output logic                     first_on_line,
	output logic [2:0]               error_kind,
	output logic                     last_of_run
);

	// Input stage
	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic        consume;

	// Scanner state
	tft_pkg::mode_t mode_q, mode_d;
	logic [15:0]    row_q, row_d;
	logic [15:0]    col_q, col_d;
	logic           lsp_q, lsp_d;
	logic [15:0]    srow_q, srow_d;
	logic [15:0]    scol_q, scol_d;
	logic [15:0]    len_q, len_d;
	logic           sfirst_q, sfirst_d;
	tft_pkg::word_t word_q, word_d;

	// Scan results
	tft_pkg::res_t  pre_res, idle_res, res0, res1;
	logic           pre_valid, idle_valid, do_idle;
	logic [1:0]     res_n, push_n;

	// Result queue
	tft_pkg::res_t  fifo_q [tft_pkg::RES_DEPTH];
	logic [1:0]     wr_ptr_q, rd_ptr_q;
	logic [2:0]     cnt_q;
	logic           pop;
	tft_pkg::res_t  head;

	// Take a byte when the stage is empty or moving on this cycle
	assign consume  = v_s1 && (cnt_q <= 3'd2);
	assign in_ready = !v_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= char_byte;
			end_s1  <= end_marker;
		end
	end

	// Scan one byte: pending token first, then the byte as a fresh start
	always_comb begin
		mode_d    = mode_q;
		row_d     = row_q;
		col_d     = col_q;
		lsp_d     = lsp_q;
		srow_d    = srow_q;
		scol_d    = scol_q;
		len_d     = len_q;
		sfirst_d  = sfirst_q;
		word_d    = word_q;
		do_idle   = 1'b0;
		pre_valid = 1'b0;
		pre_res   = '{kind: tft_pkg::K_IDENT, row: srow_q, col: scol_q, len: len_q,
			first: sfirst_q, err: tft_pkg::E_NONE, last: 1'b0};
		idle_valid = 1'b0;
		idle_res   = '{kind: tft_pkg::K_END, row: row_q, col: col_q, len: 16'd0,
			first: 1'b0, err: tft_pkg::E_NONE, last: 1'b0};

		if (end_s1) begin
			// Flush the pending token, then the end token
			idle_valid = 1'b1;
			unique case (mode_q)
				tft_pkg::M_IDENT: begin
					pre_valid = 1'b1;
					if (tft_pkg::word_done(word_q, len_q, 1'b0)) begin
						pre_res.kind = (word_q <= tft_pkg::W_NAN) ? tft_pkg::K_NUMBER
							: tft_pkg::K_KEYWORD;
					end
				end
				tft_pkg::M_NUM: begin
					pre_valid    = 1'b1;
					pre_res.kind = tft_pkg::K_NUMBER;
				end
				tft_pkg::M_SIGN: begin
					pre_valid    = 1'b1;
					pre_res.kind = tft_pkg::K_PUNCT;
				end
				tft_pkg::M_STR, tft_pkg::M_ESC: begin
					pre_valid   = 1'b1;
					pre_res     = '{kind: tft_pkg::K_ERROR, row: row_q, col: col_q,
						len: 16'd0, first: sfirst_q, err: tft_pkg::E_EOF_STR, last: 1'b0};
					if (mode_q == tft_pkg::M_ESC) begin
						pre_res.err = tft_pkg::E_BAD_ESCAPE;
					end
				end
				tft_pkg::M_AT: begin
					pre_valid    = 1'b1;
					pre_res.kind = tft_pkg::K_PUNCT;
					pre_res.len  = 16'd1;
				end
				tft_pkg::M_DIR: begin
					pre_valid    = 1'b1;
					pre_res.kind = tft_pkg::K_DIRECTIVE;
				end
				default: begin
				end
			endcase
			mode_d   = tft_pkg::M_IDLE;
			row_d    = 16'd1;
			col_d    = 16'd1;
			lsp_d    = 1'b1;
			srow_d   = 16'd0;
			scol_d   = 16'd0;
			len_d    = 16'd0;
			sfirst_d = 1'b0;
			word_d   = tft_pkg::W_NONE;
		end else begin
			unique case (mode_q)
				tft_pkg::M_COMMENT: begin
					if (byte_s1 == tft_pkg::CH_LF) begin
						do_idle = 1'b1;
					end else begin
						col_d = tft_pkg::sat_inc(col_q);
					end
				end
				tft_pkg::M_IDENT: begin
					if (tft_pkg::ident_part(byte_s1)) begin
						word_d = tft_pkg::word_step(word_q, len_q, 1'b0, byte_s1);
						len_d  = tft_pkg::sat_inc(len_q);
						col_d  = tft_pkg::sat_inc(col_q);
					end else begin
						pre_valid = 1'b1;
						if (tft_pkg::word_done(word_q, len_q, 1'b0)) begin
							pre_res.kind = (word_q <= tft_pkg::W_NAN) ? tft_pkg::K_NUMBER
								: tft_pkg::K_KEYWORD;
						end
						do_idle = 1'b1;
					end
				end
				tft_pkg::M_SIGN: begin
					if (byte_s1 == tft_pkg::CH_LF) begin
						pre_valid    = 1'b1;
						pre_res.kind = tft_pkg::K_PUNCT;
						do_idle      = 1'b1;
					end else begin
						word_d = (byte_s1 == 8'h69) ? tft_pkg::W_INF : tft_pkg::W_NONE;
						len_d  = tft_pkg::sat_inc(len_q);
						col_d  = tft_pkg::sat_inc(col_q);
						mode_d = tft_pkg::M_NUM;
					end
				end
				tft_pkg::M_NUM: begin
					if (tft_pkg::word_done(word_q, len_q, 1'b1)) begin
						if (tft_pkg::ident_part(byte_s1)) begin
							word_d = tft_pkg::W_NONE;
							len_d  = tft_pkg::sat_inc(len_q);
							col_d  = tft_pkg::sat_inc(col_q);
						end else begin
							pre_valid    = 1'b1;
							pre_res.kind = tft_pkg::K_NUMBER;
							do_idle      = 1'b1;
						end
					end else if (tft_pkg::num_part(byte_s1)) begin
						word_d = tft_pkg::word_step(word_q, len_q, 1'b1, byte_s1);
						len_d  = tft_pkg::sat_inc(len_q);
						col_d  = tft_pkg::sat_inc(col_q);
					end else begin
						pre_valid    = 1'b1;
						pre_res.kind = tft_pkg::K_NUMBER;
						do_idle      = 1'b1;
					end
				end
				tft_pkg::M_STR: begin
					if (byte_s1 == tft_pkg::CH_QUOTE) begin
						pre_valid    = 1'b1;
						pre_res.kind = tft_pkg::K_STRING;
						col_d        = tft_pkg::sat_inc(col_q);
						mode_d       = tft_pkg::M_IDLE;
					end else if (byte_s1 == tft_pkg::CH_LF) begin
						pre_valid = 1'b1;
						pre_res   = '{kind: tft_pkg::K_ERROR, row: row_q, col: col_q,
							len: 16'd0, first: sfirst_q, err: tft_pkg::E_NL_STR, last: 1'b0};
						do_idle   = 1'b1;
					end else begin
						len_d = tft_pkg::sat_inc(len_q);
						col_d = tft_pkg::sat_inc(col_q);
						if (byte_s1 == tft_pkg::CH_BSLASH) begin
							mode_d = tft_pkg::M_ESC;
						end
					end
				end
				tft_pkg::M_ESC: begin
					if (byte_s1 == tft_pkg::CH_LF) begin
						pre_valid = 1'b1;
						pre_res   = '{kind: tft_pkg::K_ERROR, row: row_q, col: col_q,
							len: 16'd0, first: sfirst_q, err: tft_pkg::E_BAD_ESCAPE,
							last: 1'b0};
						do_idle   = 1'b1;
					end else begin
						len_d  = tft_pkg::sat_inc(len_q);
						col_d  = tft_pkg::sat_inc(col_q);
						mode_d = tft_pkg::M_STR;
					end
				end
				tft_pkg::M_AT: begin
					len_d = 16'd1;
					if (tft_pkg::ident_start(byte_s1)) begin
						col_d  = tft_pkg::sat_inc(col_q);
						mode_d = tft_pkg::M_DIR;
					end else begin
						pre_valid    = 1'b1;
						pre_res.kind = tft_pkg::K_PUNCT;
						pre_res.len  = 16'd1;
						do_idle      = 1'b1;
					end
				end
				tft_pkg::M_DIR: begin
					if (tft_pkg::ident_part(byte_s1)) begin
						len_d = tft_pkg::sat_inc(len_q);
						col_d = tft_pkg::sat_inc(col_q);
					end else begin
						pre_valid    = 1'b1;
						pre_res.kind = tft_pkg::K_DIRECTIVE;
						do_idle      = 1'b1;
					end
				end
				default: begin
					do_idle = 1'b1;
				end
			endcase

			// Handle the byte between tokens
			if (do_idle) begin
				mode_d = tft_pkg::M_IDLE;
				if (byte_s1 == tft_pkg::CH_LF) begin
					row_d = tft_pkg::sat_inc(row_q);
					col_d = 16'd1;
					lsp_d = 1'b1;
				end else begin
					priority if (tft_pkg::is_space(byte_s1)) begin
						mode_d = tft_pkg::M_IDLE;
					end else if (byte_s1 == tft_pkg::CH_HASH) begin
						mode_d = tft_pkg::M_COMMENT;
					end else if (tft_pkg::ident_start(byte_s1) ||
							tft_pkg::is_digit(byte_s1) ||
							byte_s1 == tft_pkg::CH_PLUS || byte_s1 == tft_pkg::CH_MINUS ||
							byte_s1 == tft_pkg::CH_QUOTE || byte_s1 == tft_pkg::CH_AT) begin
						srow_d   = row_q;
						scol_d   = col_q;
						sfirst_d = lsp_q;
						lsp_d    = 1'b0;
						len_d    = 16'd1;
						word_d   = tft_pkg::W_NONE;
						priority if (tft_pkg::ident_start(byte_s1)) begin
							mode_d = tft_pkg::M_IDENT;
							word_d = tft_pkg::word_first(byte_s1);
						end else if (tft_pkg::is_digit(byte_s1)) begin
							mode_d = tft_pkg::M_NUM;
						end else if (byte_s1 == tft_pkg::CH_QUOTE) begin
							mode_d = tft_pkg::M_STR;
							len_d  = 16'd0;
						end else if (byte_s1 == tft_pkg::CH_AT) begin
							mode_d = tft_pkg::M_AT;
							len_d  = 16'd0;
						end else begin
							mode_d = tft_pkg::M_SIGN;
						end
					end else begin
						lsp_d      = 1'b0;
						idle_valid = 1'b1;
						idle_res   = '{kind: tft_pkg::K_PUNCT, row: row_q, col: col_q,
							len: 16'd1, first: lsp_q, err: tft_pkg::E_NONE, last: 1'b0};
						if (!tft_pkg::is_punct(byte_s1)) begin
							idle_res.kind = tft_pkg::K_ERROR;
							idle_res.err  = tft_pkg::E_BAD_CHAR;
						end
					end
					col_d = tft_pkg::sat_inc(col_q);
				end
			end
		end
	end

	// Order results and mark the last one of this byte
	always_comb begin
		res0  = pre_valid ? pre_res : idle_res;
		res1  = idle_res;
		res_n = {1'b0, pre_valid} + {1'b0, idle_valid};
		if (res_n == 2'd2) begin
			res1.last = 1'b1;
		end else begin
			res0.last = 1'b1;
		end
	end

	assign push_n = consume ? res_n : 2'd0;

	// Advance the scanner state on each scanned byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= tft_pkg::M_IDLE;
			row_q    <= 16'd1;
			col_q    <= 16'd1;
			lsp_q    <= 1'b1;
			srow_q   <= 16'd0;
			scol_q   <= 16'd0;
			len_q    <= 16'd0;
			sfirst_q <= 1'b0;
			word_q   <= tft_pkg::W_NONE;
		end else if (consume) begin
			mode_q   <= mode_d;
			row_q    <= row_d;
			col_q    <= col_d;
			lsp_q    <= lsp_d;
			srow_q   <= srow_d;
			scol_q   <= scol_d;
			len_q    <= len_d;
			sfirst_q <= sfirst_d;
			word_q   <= word_d;
		end
	end

	// Result queue: up to two writes, one read per cycle
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			cnt_q    <= cnt_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (push_n == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= res1;
		end
	end

	// Drive the head entry
	assign head          = fifo_q[rd_ptr_q];
	assign out_valid     = cnt_q != 3'd0;
	assign token_kind    = head.kind;
	assign token_row     = head.row;
	assign token_col     = head.col;
	assign token_length  = head.len;
	assign first_on_line = head.first;
	assign error_kind    = head.err;
	assign last_of_run   = head.last;

	// Checks
	`ASSERT_NEVER(a_queue_bound, clk, arst_n, cnt_q > 3'd4)
	`ASSERT_PROP(a_end_emits, clk, arst_n, (consume && end_s1) |-> (push_n != 2'd0))
	`ASSERT_PROP(a_end_restarts, clk, arst_n,
		(consume && end_s1) |=> (mode_q == tft_pkg::M_IDLE && row_q == 16'd1 && col_q == 16'd1))
	`ASSERT_PROP(a_last_marks, clk, arst_n,
		(push_n == 2'd2) |-> (!res0.last && res1.last))

endmodule

`default_nettype wire
